// ===== hdl/qu_pkg.sv =====
package qu_pkg;

  localparam int NODES_DEF = 1024;
  localparam int NODE_W    = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // write one entry of the init sweep
    logic load_a;    // take the input word, start walk from node_a
    logic load_b;    // save root of a, start walk from node_b
    logic follow;    // step one parent link up
    logic link;      // parent[root_a] <= root_b
    logic res_load;
    logic res_val;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic in_bad;    // an input index is outside the table
    logic is_root;
    logic roots_eq;
  } dp_sts_t;

endpackage

// ===== hdl/qu_ctrl.sv =====
module qu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output qu_pkg::dp_cmd_t cmd,
  input  qu_pkg::dp_sts_t sts
);

  qu_pkg::state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == qu_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qu_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qu_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = qu_pkg::ST_IDLE;
      end
      qu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_bad ? qu_pkg::ST_FINISH : qu_pkg::ST_WALK_A;
        end
      end
      qu_pkg::ST_WALK_A: begin
        if (sts.is_root) state_nxt = qu_pkg::ST_WALK_B;
      end
      qu_pkg::ST_WALK_B: begin
        if (sts.is_root) state_nxt = qu_pkg::ST_FINISH;
      end
      qu_pkg::ST_FINISH: begin
        if (out_free) state_nxt = qu_pkg::ST_IDLE;
      end
      default: state_nxt = qu_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      qu_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      qu_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_a = 1'b1;
          if (sts.in_bad) begin
            cmd.res_load = 1'b1;
            cmd.res_val  = 1'b1;
          end
        end
      end
      qu_pkg::ST_WALK_A: begin
        if (sts.is_root) cmd.load_b = 1'b1;
        else             cmd.follow = 1'b1;
      end
      qu_pkg::ST_WALK_B: begin
        if (sts.is_root) begin
          cmd.res_load = 1'b1;
          cmd.res_val  = sts.roots_eq;
          cmd.link     = !sts.roots_eq;
        end else begin
          cmd.follow = 1'b1;
        end
      end
      qu_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/qu_dp.sv =====
module qu_dp #(
  parameter int NODES = qu_pkg::NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [qu_pkg::NODE_W-1:0] in_node_a,
  input  logic [qu_pkg::NODE_W-1:0] in_node_b,
  output logic                      out_already_connected,
  input  qu_pkg::dp_cmd_t           cmd,
  output qu_pkg::dp_sts_t           sts
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  // wide enough for both the input field and the node count
  localparam int CW = (NW + 1 > qu_pkg::NODE_W) ? NW + 1 : qu_pkg::NODE_W;

  logic [NW-1:0] mem [NODES];

  logic [NW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic [NW-1:0] ra_r, ra_nxt;
  logic [NW-1:0] rdata_r;
  logic [NW-1:0] rd_addr;
  logic          res_r, res_nxt;
  logic          out_r, out_nxt;
  logic [CW-1:0] a_x, b_x;
  logic [NW-1:0] a_idx, b_idx;

  assign a_x   = CW'(in_node_a);
  assign b_x   = CW'(in_node_b);
  assign a_idx = a_x[NW-1:0];
  assign b_idx = b_x[NW-1:0];

  assign sts.in_bad   = (a_x >= CW'(NODES)) || (b_x >= CW'(NODES));
  assign sts.clr_done = (clr_cnt_r == NW'(NODES - 1));
  assign sts.is_root  = (rdata_r == cur_r);
  assign sts.roots_eq = (cur_r == ra_r);

  assign out_already_connected = out_r;

  always_comb begin
    clr_cnt_nxt = cmd.clr_step ? clr_cnt_r + 1'b1 : clr_cnt_r;
    cur_nxt     = cur_r;
    b_nxt       = b_r;
    ra_nxt      = ra_r;
    rd_addr     = cur_r;
    res_nxt     = cmd.res_load ? cmd.res_val : res_r;
    out_nxt     = cmd.out_load ? res_r : out_r;
    if (cmd.load_a) begin
      cur_nxt = a_idx;
      b_nxt   = b_idx;
      rd_addr = a_idx;
    end else if (cmd.load_b) begin
      ra_nxt  = cur_r;
      cur_nxt = b_r;
      rd_addr = b_r;
    end else if (cmd.follow) begin
      cur_nxt = rdata_r;
      rd_addr = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    b_r   <= b_nxt;
    ra_r  <= ra_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // parent table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= clr_cnt_r;
    end else if (cmd.link) begin
      mem[ra_r] <= cur_r;
    end
    rdata_r <= mem[rd_addr];
  end

endmodule

// ===== hdl/quick_union_connectivity.sv =====
// quick-union connectivity engine
// input channel: in_valid/in_ready with a pair of node indices in_node_a and
// in_node_b. output channel: out_valid/out_ready with one word per input,
// out_already_connected = 1 when both nodes already share a root (no change),
// 0 when the root of node_a was linked under the root of node_b.
// an index of NODES or more gives 1 and leaves the table alone.
// after reset the parent table is initialized one entry per cycle, so
// in_ready stays low until all NODES entries (1024 by default) are written.
// one item is worked at a time. each root walk follows one parent link at
// a time through the single read port of the parent memory, and the next
// item is taken the cycle after the result is loaded; depths range from 0
// to NODES-1.
// the result sits in an output register; a new item is accepted while it
// waits, and the engine only holds before loading the next result until
// the receiver takes the previous one.
module quick_union_connectivity #(
  parameter int NODES = qu_pkg::NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qu_pkg::NODE_W-1:0] in_node_a,
  input  logic [qu_pkg::NODE_W-1:0] in_node_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_already_connected
);

  qu_pkg::dp_cmd_t cmd;
  qu_pkg::dp_sts_t sts;

  qu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  qu_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_node_a             (in_node_a),
    .in_node_b             (in_node_b),
    .out_already_connected (out_already_connected),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule

// ===== hdl/qu_checker.sv =====
module qu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [qu_pkg::NODE_W-1:0] in_node_a,
  input logic [qu_pkg::NODE_W-1:0] in_node_b,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_already_connected
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_already_connected))
    else $error("result word changed while stalled");

  // waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_node_a) && $stable(in_node_b))
    else $error("input word changed while waiting");

  // reset starts the init sweep with nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channels active right after reset");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

endmodule

bind quick_union_connectivity qu_checker u_qu_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_node_a             (in_node_a),
  .in_node_b             (in_node_b),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_already_connected (out_already_connected)
);
